@@ rtl/m4rm_pkg.sv @@
package m4rm_pkg;

	localparam int Q_W       = 32;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = 2 * Q_W;
	localparam int HALF_W    = PROD_W + 1;
	localparam int SUM_W     = PROD_W + 2;
	localparam int SHIFT_W   = SUM_W - FRAC_W;
	localparam int NUM_REGS  = 8;
	localparam int REG_W     = 64;
	localparam int REG_IDX_W = 3;
	localparam int ADDR_W    = REG_IDX_W + 3;

	typedef logic signed [Q_W-1:0] q16_t;
	typedef q16_t [3:0] row_t;
	typedef row_t [3:0] mat_t;
	typedef logic [NUM_REGS-1:0][REG_W-1:0] regfile_t;

	localparam q16_t Q_MAX = 32'sh7fff_ffff;
	localparam q16_t Q_MIN = 32'sh8000_0000;

	localparam regfile_t REG_RESET = {
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000
	};

endpackage

@@ rtl/m4rm_cfg.sv @@
module m4rm_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [m4rm_pkg::ADDR_W-1:0] paddr,
	input  logic [m4rm_pkg::REG_W-1:0]  pwdata,
	output logic [m4rm_pkg::REG_W-1:0]  prdata,
	output logic                        pready,
	output m4rm_pkg::mat_t              bmat
);
	import m4rm_pkg::*;

	regfile_t               regs_q;
	logic                   wr_en;
	logic [REG_IDX_W-1:0]   idx;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:3];
	assign wr_en  = psel && penable && pwrite && pready;
	assign prdata = regs_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= REG_RESET;
		end else if (wr_en) begin
			regs_q[idx] <= pwdata;
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_row
		for (genvar j = 0; j < 4; j++) begin : g_col
			assign bmat[k][j] = regs_q[k*2 + j/2][Q_W*(j%2) +: Q_W];
		end
	end

	a_write_lands: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> regs_q[$past(idx)] == $past(pwdata))
		else $error("register write not stored");

	a_hold_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		!wr_en |=> $stable(regs_q))
		else $error("register changed without a write");

endmodule

@@ rtl/m4rm_pipe.sv @@
module m4rm_pipe (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  m4rm_pkg::row_t in_row,
	input  m4rm_pkg::mat_t bmat,
	output logic           out_valid,
	input  logic           out_ready,
	output m4rm_pkg::row_t out_row,
	output logic           out_sat
);
	import m4rm_pkg::*;

	logic                      v_s1, v_s2, v_s3;
	logic                      rdy1, rdy2, rdy3;
	logic signed [PROD_W-1:0]  prod_s1 [4][4];
	logic signed [HALF_W-1:0]  half_s2 [4][2];
	row_t                      row_s3;
	logic                      sat_s3;
	logic signed [SUM_W-1:0]   total   [4];
	logic signed [SHIFT_W-1:0] shifted [4];
	logic [3:0]                ovf;
	row_t                      clamp;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			for (int j = 0; j < 4; j++) begin
				for (int k = 0; k < 4; k++) begin
					prod_s1[j][k] <= in_row[k] * bmat[k][j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			for (int j = 0; j < 4; j++) begin
				half_s2[j][0] <= {prod_s1[j][0][PROD_W-1], prod_s1[j][0]}
					+ {prod_s1[j][1][PROD_W-1], prod_s1[j][1]};
				half_s2[j][1] <= {prod_s1[j][2][PROD_W-1], prod_s1[j][2]}
					+ {prod_s1[j][3][PROD_W-1], prod_s1[j][3]};
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			total[j]   = {half_s2[j][0][HALF_W-1], half_s2[j][0]}
				+ {half_s2[j][1][HALF_W-1], half_s2[j][1]};
			shifted[j] = total[j][SUM_W-1:FRAC_W];
			ovf[j]     = !((&shifted[j][SHIFT_W-1:Q_W-1])
				|| !(|shifted[j][SHIFT_W-1:Q_W-1]));
			if (ovf[j]) begin
				clamp[j] = shifted[j][SHIFT_W-1] ? Q_MIN : Q_MAX;
			end else begin
				clamp[j] = shifted[j][Q_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			row_s3 <= clamp;
			sat_s3 <= |ovf;
		end
	end

	assign out_valid = v_s3;
	assign out_row   = row_s3;
	assign out_sat   = sat_s3;

	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && sat_s3) |-> (row_s3[0] == Q_MAX || row_s3[0] == Q_MIN
			|| row_s3[1] == Q_MAX || row_s3[1] == Q_MIN
			|| row_s3[2] == Q_MAX || row_s3[2] == Q_MIN
			|| row_s3[3] == Q_MAX || row_s3[3] == Q_MIN))
		else $error("saturation flag without a clamped element");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted beat lost at stage 1");

	a_s1_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && rdy2) |=> v_s2)
		else $error("stage 1 beat lost at stage 2");

endmodule

@@ rtl/matrix4_row_multiply.sv @@
// Streams rows of a left-hand 4x4 matrix through a product with a right-hand
// 4x4 matrix held in configuration registers; all values signed Q16.16.
// Input channel s_*: one beat per row, s_tdata holds in_c0..in_c3.
// Output channel m_*: one beat per input beat, in order; m_tdata holds
// out_c0..out_c3, m_tuser[0] flags that an element was clamped to 32 bits.
// Each output element is the exact sum of four 64-bit products, shifted right
// arithmetically by 16 and saturated.
// A beat accepted on s_* passes the multiply, pair add, and final add and
// clamp stages before it shows on m_tvalid. Throughput: the sixteen parallel
// 32x32 multipliers in stage 1 give one beat per cycle while m_tready is high.
// Configuration: APB, eight 64-bit registers at 8*i, row k of the matrix in
// registers 2k (columns 0,1) and 2k+1 (columns 2,3). Write only while idle.
// Reset clears the pipeline and loads the identity matrix.
// When m_tready is low the output beat holds; earlier stages keep filling and
// s_tready drops only once every stage holds a beat.
module matrix4_row_multiply (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [127:0]                s_tdata,  // in_c0, in_c1, in_c2, in_c3
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [127:0]                m_tdata,  // out_c0, out_c1, out_c2, out_c3
	output logic [0:0]                  m_tuser,  // saturated
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [m4rm_pkg::ADDR_W-1:0] paddr,
	input  logic [m4rm_pkg::REG_W-1:0]  pwdata,
	output logic [m4rm_pkg::REG_W-1:0]  prdata,
	output logic                        pready
);
	import m4rm_pkg::*;

	mat_t bmat;
	row_t in_row;
	row_t out_row;
	logic out_sat;

	for (genvar i = 0; i < 4; i++) begin : g_pack
		assign in_row[i]               = s_tdata[Q_W*i +: Q_W];
		assign m_tdata[Q_W*i +: Q_W]   = out_row[i];
	end

	assign m_tuser[0] = out_sat;

	m4rm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.bmat    (bmat)
	);

	m4rm_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_row    (in_row),
		.bmat      (bmat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_row   (out_row),
		.out_sat   (out_sat)
	);

endmodule
